@@ hw/rtl/checked_stack_calculator_assert.svh @@
// assertion macros for the stack calculator
`ifndef CHECKED_STACK_CALCULATOR_ASSERT_SVH
`define CHECKED_STACK_CALCULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSC_ASSERT(label, clk, rst_n, prop, msg)
`define CSC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/csc_pkg.sv @@
// shared types and codes for the stack calculator
package csc_pkg;
  localparam int unsigned DataW = 64;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0, OP_POP = 4'd1, OP_PUSHL = 4'd2, OP_PUSHV = 4'd3, OP_PEEK = 4'd4,
    OP_ABS = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7, OP_DIV = 4'd8, OP_MUL = 4'd9,
    OP_PRINT = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_FULL = 3'd4,
    ST_BADOP = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture command, start operand reads
    logic rd_top;   // register top/second operands
    logic start;    // evaluate / start iterative unit
    logic commit;   // write back and present result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;     // iterative unit running
  } dp_sts_t;
endpackage

@@ hw/rtl/checked_stack_calculator.sv @@
// checked stack calculator top level
//
// channel  direction  handshake               payload
// in       input      in_valid_i/in_stall_o    opcode, literal_value, var_index
// out      output     out_valid_o/out_stall_i  status, print_valid, print_value
//
// one command at a time; divide runs the shift-subtract divider (one quotient
// bit a cycle), multiply sums four partial products
// reset clears the stack count and marks every variable as zero
// a held result blocks the next command only while out_stall_i is high
`include "checked_stack_calculator_assert.svh"
module checked_stack_calculator import csc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VAR_COUNT   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        opcode_i,
  input  logic signed [63:0] literal_value_i,
  input  logic [3:0]        var_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              print_valid_o,
  output logic signed [63:0] print_value_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  csc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  csc_dpath #(.StackDepth(STACK_DEPTH), .VarCount(VAR_COUNT)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .literal_value_i(literal_value_i), .var_index_i,
    .status_o, .print_valid_o, .print_value_o(print_value_o)
  );

  `CSC_ASSERT(a_cmd_onehot0, clk_i, rst_ni, $onehot0(cmd), "more than one datapath command")
  `CSC_ASSERT(a_no_accept_busy, clk_i, rst_ni, sts.busy |-> in_stall_o, "accept while busy")
  `CSC_ASSERT(a_print_ok, clk_i, rst_ni, (out_valid_o && print_valid_o) |-> (status_o == ST_OK), "print with error")
  `CSC_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o, "result during reset")
endmodule

@@ hw/rtl/csc_ctrl.sv @@
// command sequencing state machine
module csc_ctrl import csc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_OPND = 6'b000100,
    S_RUN = 6'b001000, S_WB = 6'b010000, S_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  // accept when idle and the output slot can take the result
  assign in_stall_o  = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_top = 1'b1;
        state_d      = S_OPND;
      end
      S_OPND: begin
        cmd_o.start = 1'b1;
        state_d     = S_RUN;
      end
      S_RUN: begin
        if (!sts_i.busy) state_d = S_WB;
      end
      S_WB: begin
        if (!(ov_q && out_stall_i)) begin
          cmd_o.commit = 1'b1;
          ov_d         = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule

@@ hw/rtl/csc_div.sv @@
// radix-2 unsigned divider, one quotient bit a cycle
module csc_div import csc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             busy_o,
  output logic [DataW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(DataW + 1);
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] quo_q, quo_d, den_q, den_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW:0]   trial;

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign trial  = {rem_q, quo_q[DataW-1]} - {1'b0, den_q};

  // shift-subtract step, remainder stays below the divisor magnitude
  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CntW'(DataW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - CntW'(1);
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule

@@ hw/rtl/csc_mul.sv @@
// 64x64 unsigned multiplier from four 32x32 partial products over cycles
module csc_mul import csc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             busy_o,
  output logic [2*DataW-1:0] prod_o
);
  localparam int unsigned HalfW = DataW / 2;
  logic [2:0]         step_q;
  logic [DataW-1:0]   a_q, b_q;
  logic [DataW-1:0]   pp_q;
  logic [2*DataW-1:0] acc_q;
  logic [HalfW-1:0]   ma, mb;
  logic [$clog2(DataW)+1:0] sh_q;

  assign busy_o = (step_q != '0);
  assign prod_o = acc_q;

  // step selects partial product operands
  always_comb begin
    case (step_q)
      3'd5: begin ma = a_q[HalfW-1:0];     mb = b_q[HalfW-1:0];     end
      3'd4: begin ma = a_q[DataW-1:HalfW]; mb = b_q[HalfW-1:0];     end
      3'd3: begin ma = a_q[HalfW-1:0];     mb = b_q[DataW-1:HalfW]; end
      default: begin ma = a_q[DataW-1:HalfW]; mb = b_q[DataW-1:HalfW]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= '0;
    else if (start_i) step_q <= 3'd6;
    else if (busy_o) step_q <= step_q - 3'd1;
  end

  // registered partial product, then shifted accumulate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_o) begin
      if (step_q <= 3'd5 && step_q >= 3'd2) pp_q <= DataW'(ma) * DataW'(mb);
      if (step_q <= 3'd4) acc_q <= acc_q + ((2*DataW)'(pp_q) << sh_q);
      case (step_q)
        3'd5: sh_q <= '0;
        3'd4: sh_q <= ($clog2(DataW)+2)'(HalfW);
        3'd3: sh_q <= ($clog2(DataW)+2)'(HalfW);
        default: sh_q <= ($clog2(DataW)+2)'(DataW);
      endcase
    end
  end
endmodule

@@ hw/rtl/csc_dpath.sv @@
// stack, variable table and checked arithmetic
module csc_dpath import csc_pkg::*; #(
  parameter int unsigned StackDepth = 64,
  parameter int unsigned VarCount   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [3:0]       opcode_i,
  input  logic [DataW-1:0] literal_value_i,
  input  logic [3:0]       var_index_i,
  output logic [2:0]       status_o,
  output logic             print_valid_o,
  output logic [DataW-1:0] print_value_o
);
  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CW = $clog2(StackDepth + 1);
  localparam int unsigned VW = (VarCount > 1) ? $clog2(VarCount) : 1;
  localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

  logic [DataW-1:0] stack_mem [StackDepth];
  logic [DataW-1:0] var_mem [VarCount];
  logic [VarCount-1:0] var_vld_q;

  logic [CW-1:0]    cnt_q;
  logic [3:0]       op_q;
  logic [DataW-1:0] lit_q, top_q, sec_q, var_q;
  logic [3:0]       vi_q;
  logic             vi_ok;
  logic [DataW-1:0] rd1_q, rd2_q;
  logic [2:0]       st_q;
  logic [DataW-1:0] res_q;
  logic             neg_q;
  logic [2:0]       status_q;
  logic             pv_q;
  logic [DataW-1:0] pval_q;
  logic [AW-1:0]    a1, a2;

  assign vi_ok = (32'(vi_q) < VarCount);
  assign a1 = AW'(cnt_q - CW'(1));
  assign a2 = AW'(cnt_q - CW'(2));

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      lit_q <= literal_value_i;
      vi_q  <= var_index_i;
    end
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    rd1_q <= stack_mem[a1];
    rd2_q <= stack_mem[a2];
    var_q <= var_vld_q[VW'(vi_q)] ? var_mem[VW'(vi_q)] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_top) begin
      top_q <= rd1_q;
      sec_q <= rd2_q;
    end
  end

  // magnitudes
  logic [DataW-1:0] mt, ms;
  logic             sgn_diff;
  assign mt = top_q[DataW-1] ? (DataW'(0) - top_q) : top_q;
  assign ms = sec_q[DataW-1] ? (DataW'(0) - sec_q) : sec_q;
  assign sgn_diff = top_q[DataW-1] ^ sec_q[DataW-1];

  logic div_busy, mul_busy, is_div, is_mul;
  logic [DataW-1:0] quo;
  logic [2*DataW-1:0] prod;
  assign is_div = (op_q == OP_DIV);
  assign is_mul = (op_q == OP_MUL);

  csc_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.start && is_div), .num_i(ms), .den_i(mt),
    .busy_o(div_busy), .quo_o(quo)
  );
  csc_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(cmd_i.start && is_mul), .a_i(ms), .b_i(mt),
    .busy_o(mul_busy), .prod_o(prod)
  );
  assign sts_o.busy = div_busy | mul_busy;

  // combinational evaluation of checks and simple ops, registered on start
  logic [DataW-1:0] sum, dif;
  logic [2:0]       st_d;
  logic [DataW-1:0] res_d;
  assign sum = sec_q + top_q;
  assign dif = sec_q - top_q;
  always_comb begin
    st_d  = ST_OK;
    res_d = '0;
    case (op_q)
      OP_NOP: ;
      OP_POP, OP_PEEK, OP_PRINT: if (cnt_q == '0) st_d = ST_UNDER;
      OP_PUSHL, OP_PUSHV: if (32'(cnt_q) >= StackDepth) st_d = ST_FULL;
      OP_ABS: begin
        if (cnt_q == '0) st_d = ST_UNDER;
        else if (top_q == SignBit) st_d = ST_OVER;
        res_d = mt;
      end
      OP_ADD: begin
        if (cnt_q < CW'(2)) st_d = ST_UNDER;
        else if (((sec_q ^ sum) & (top_q ^ sum) & SignBit) != '0) st_d = ST_OVER;
        res_d = sum;
      end
      OP_SUB: begin
        if (cnt_q < CW'(2)) st_d = ST_UNDER;
        else if (((sec_q ^ top_q) & (sec_q ^ dif) & SignBit) != '0) st_d = ST_OVER;
        res_d = dif;
      end
      OP_DIV: begin
        if (cnt_q < CW'(2)) st_d = ST_UNDER;
        else if (top_q == '0) st_d = ST_DIVZ;
        else if (sec_q == SignBit && top_q == '1) st_d = ST_OVER;
      end
      OP_MUL: if (cnt_q < CW'(2)) st_d = ST_UNDER;
      default: st_d = ST_BADOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      st_q  <= st_d;
      res_q <= res_d;
      neg_q <= sgn_diff;
    end
  end

  // final result and overflow check of the product
  logic [2:0]       fst;
  logic [DataW-1:0] fres, q_s, p_s;
  logic [DataW:0]   limit;
  assign q_s = neg_q ? (DataW'(0) - quo) : quo;
  assign p_s = neg_q ? (DataW'(0) - prod[DataW-1:0]) : prod[DataW-1:0];
  assign limit = neg_q ? {1'b0, SignBit} : {1'b0, SignBit - DataW'(1)};
  always_comb begin
    fst  = st_q;
    fres = res_q;
    if (is_div) fres = q_s;
    if (is_mul) begin
      fres = p_s;
      if (st_q == ST_OK && (prod[2*DataW-1:DataW] != '0 || {1'b0, prod[DataW-1:0]} > limit))
        fst = ST_OVER;
    end
  end

  // write back
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fst == ST_OK) begin
      case (op_q)
        OP_PUSHL: stack_mem[AW'(cnt_q)] <= lit_q;
        OP_PUSHV: stack_mem[AW'(cnt_q)] <= vi_ok ? var_q : '0;
        OP_ABS: stack_mem[a1] <= fres;
        OP_ADD, OP_SUB, OP_DIV, OP_MUL: stack_mem[a2] <= fres;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fst == ST_OK && op_q == OP_PEEK && vi_ok)
      var_mem[VW'(vi_q)] <= top_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      var_vld_q <= '0;
      status_q  <= ST_OK;
      pv_q      <= 1'b0;
      pval_q    <= '0;
    end else if (cmd_i.commit) begin
      status_q <= fst;
      pv_q     <= 1'b0;
      pval_q   <= '0;
      if (fst == ST_OK) begin
        case (op_q)
          OP_POP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: cnt_q <= cnt_q - CW'(1);
          OP_PUSHL: begin
            cnt_q <= cnt_q + CW'(1); pv_q <= 1'b1; pval_q <= lit_q;
          end
          OP_PUSHV: begin
            cnt_q <= cnt_q + CW'(1); pv_q <= 1'b1; pval_q <= vi_ok ? var_q : '0;
          end
          OP_PEEK: if (vi_ok) var_vld_q[VW'(vi_q)] <= 1'b1;
          OP_PRINT: begin pv_q <= 1'b1; pval_q <= top_q; end
          default: ;
        endcase
      end
    end
  end

  assign status_o      = status_q;
  assign print_valid_o = pv_q;
  assign print_value_o = pval_q;
endmodule

@@ tb/sv/checked_stack_calculator_checker.sv @@
// checker: predicts each stack calculator result and compares it with the block
`timescale 1ns / 100ps
module checked_stack_calculator_checker import csc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VAR_COUNT   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [3:0]         opcode_i,
  input  logic signed [63:0] literal_value_i,
  input  logic [3:0]         var_index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic               print_valid_i,
  input  logic signed [63:0] print_value_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]  status;
    logic        pvalid;
    logic [63:0] pvalue;
  } calc_result_t;

  logic [63:0]  model_stack [STACK_DEPTH];
  logic [63:0]  model_vars [VAR_COUNT];
  int unsigned  model_depth;
  calc_result_t result_fifo [$];

  assign pending_o = result_fifo.size();

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // checked arithmetic on two's complement operands
  function automatic status_e calc_binary(op_e op, logic [63:0] a, logic [63:0] b,
                                          output logic [63:0] r);
    logic [63:0] ma, mb, lim;
    logic        neg;
    ma = mag(a);
    mb = mag(b);
    neg = a[63] ^ b[63];
    r = '0;
    case (op)
      OP_ADD: begin
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63])) return ST_OVER;
      end
      OP_SUB: begin
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63])) return ST_OVER;
      end
      OP_DIV: begin
        if (b == '0) return ST_DIVZ;
        if (a == MinVal && b == '1) return ST_OVER;
        r = neg ? -(ma / mb) : ma / mb;
      end
      default: begin
        lim = neg ? MinVal : MinVal - 1;
        if (ma != '0 && mb > lim / ma) return ST_OVER;
        r = neg ? -(ma * mb) : ma * mb;
      end
    endcase
    return ST_OK;
  endfunction

  // apply one command to the model state
  function automatic calc_result_t run_command(logic [3:0] opc, logic [63:0] lit,
                                               logic [3:0] vi);
    calc_result_t res;
    logic [63:0]  v, r;
    res = '0;
    case (opc)
      OP_NOP: ;
      OP_POP: if (model_depth < 1) res.status = ST_UNDER; else model_depth--;
      OP_PUSHL, OP_PUSHV: begin
        if (model_depth >= STACK_DEPTH) res.status = ST_FULL;
        else begin
          v = (opc == OP_PUSHL) ? lit : ((vi < VAR_COUNT) ? model_vars[vi] : '0);
          model_stack[model_depth] = v;
          model_depth++;
          res.pvalid = 1'b1;
          res.pvalue = v;
        end
      end
      OP_PEEK: begin
        if (model_depth < 1) res.status = ST_UNDER;
        else if (vi < VAR_COUNT) model_vars[vi] = model_stack[model_depth-1];
      end
      OP_ABS: begin
        if (model_depth < 1) res.status = ST_UNDER;
        else if (model_stack[model_depth-1] == MinVal) res.status = ST_OVER;
        else model_stack[model_depth-1] = mag(model_stack[model_depth-1]);
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
        if (model_depth < 2) res.status = ST_UNDER;
        else begin
          res.status = calc_binary(op_e'(opc), model_stack[model_depth-2],
                                   model_stack[model_depth-1], r);
          if (res.status == ST_OK) begin
            model_stack[model_depth-2] = r;
            model_depth--;
          end
        end
      end
      OP_PRINT: begin
        if (model_depth < 1) res.status = ST_UNDER;
        else begin
          res.pvalid = 1'b1;
          res.pvalue = model_stack[model_depth-1];
        end
      end
      default: res.status = ST_BADOP;
    endcase
    return res;
  endfunction

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    calc_result_t want;
    if (!rst_ni) begin
      model_depth = 0;
      foreach (model_vars[i]) model_vars[i] = '0;
      result_fifo.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        result_fifo.insert(result_fifo.size(),
                           run_command(opcode_i, literal_value_i, var_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_fifo.pop_front();
          if (status_i !== want.status || print_valid_i !== want.pvalid ||
              print_value_i !== want.pvalue) begin
            if (fail_count_o < 10)
              $display("mismatch: exp st=%0d pv=%0d val=%h got st=%0d pv=%0d val=%h",
                       want.status, want.pvalid, want.pvalue,
                       status_i, print_valid_i, print_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/checked_stack_calculator_tb.sv @@
// testbench top: stimulus, idling and verdict for the stack calculator
`timescale 1ns / 100ps
module checked_stack_calculator_tb import csc_pkg::*;;
  localparam int WatchLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         opcode_i = '0;
  logic signed [63:0] literal_value_i = '0;
  logic [3:0]         var_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic               print_valid_o;
  logic signed [63:0] print_value_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 35;
  int                 recv_idle_pct = 54;
  logic               hold_off = 1'b0;
  int                 idle_cycles = 0;

  checked_stack_calculator uut (.*);

  checked_stack_calculator_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i,
    .literal_value_i, .var_index_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .print_valid_i(print_valid_o),
    .print_value_i(print_value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles without a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return '1;
      4: return 64'($signed($urandom_range(40)) - 20);
      5: return {32'h0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // send one command transaction, idling first at random
  // valid stays high after acceptance so back-to-back sends need no gap
  task automatic send_command(logic [3:0] opc, logic [63:0] lit, logic [3:0] vi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= opc;
    literal_value_i <= lit;
    var_index_i     <= vi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // random command biased to keep the stack populated
  task automatic send_random();
    int sel;
    logic [3:0] opc;
    sel = $urandom_range(99);
    if (sel < 30) opc = OP_PUSHL;
    else if (sel < 38) opc = OP_PUSHV;
    else if (sel < 44) opc = OP_PEEK;
    else if (sel < 92) opc = 4'($urandom_range(OP_PRINT));
    else opc = 4'($urandom_range(15));
    send_command(opc, rand_value(), 4'($urandom_range(15)));
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflow on empty stack, then each operation and special case
    send_command(OP_POP, '0, '0);
    send_command(OP_PRINT, '0, '0);
    send_command(OP_PUSHV, '0, 4'd15);
    send_command(OP_PUSHL, 64'h8000_0000_0000_0000, '0);
    send_command(OP_ABS, '0, '0);
    send_command(OP_PEEK, '0, 4'd3);
    send_command(OP_PUSHL, '1, '0);
    send_command(OP_DIV, '0, '0);
    send_command(OP_MUL, '0, '0);
    send_command(OP_PUSHL, '0, '0);
    send_command(OP_DIV, '0, '0);
    send_command(OP_SUB, '0, '0);
    send_command(OP_PUSHL, 64'h7fff_ffff_ffff_ffff, '0);
    send_command(OP_ADD, '0, '0);
    send_command(OP_PUSHL, -64'sd7, '0);
    send_command(OP_PUSHL, 64'sd2, '0);
    send_command(OP_DIV, '0, '0);
    send_command(OP_ABS, '0, '0);
    send_command(OP_PUSHV, '0, 4'd3);
    send_command(OP_MUL, '0, '0);
    send_command(4'd11, '0, '0);
    send_command(4'd15, '1, '1);
    send_command(OP_NOP, '1, '1);
    // fill to full stack
    repeat (66) send_command(OP_PUSHL, rand_value(), '0);

    // long receiver hold-off while the sender keeps offering
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        repeat (10) send_command(OP_PRINT, '0, '0);
        in_valid_i <= 1'b0;
      end
    join
    wait_drained();
    repeat (100) send_command(OP_POP, '0, '0);

    // random phases with different idling
    repeat (170) send_random();
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 35;
    repeat (170) send_random();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (170) send_random();

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("covered all opcodes incl. unknown ones, empty/full stack, overflow and divide by zero");
    $display("random commands ran under three idling mixes and a long receiver hold-off");
    if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ checked_stack_calculator.f @@
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_ctrl.sv
hw/rtl/csc_div.sv
hw/rtl/csc_mul.sv
hw/rtl/csc_dpath.sv
hw/rtl/checked_stack_calculator.sv
tb/sv/checked_stack_calculator_checker.sv
tb/sv/checked_stack_calculator_tb.sv
